[rtl/core/ght_pkg.sv]
// Shared types, codes and default sizes of the generational handle table.
package ght_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int GEN_BITS_DEF   = 16;
    localparam int REV_BITS_DEF   = 32;
    localparam int COORD_BITS_DEF = 16;

    // Occupancy is kept as words of this many slots each.
    localparam int OCC_WORD_BITS = 32;

    typedef enum logic [2:0] {
        FN_CREATE  = 3'd0,
        FN_STORE   = 3'd1,
        FN_SET     = 3'd2,
        FN_RELEASE = 3'd3,
        FN_STALE   = 3'd4,
        FN_LOOKUP  = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        STAT_PENDING     = 3'd0,
        STAT_READY       = 3'd1,
        STAT_UNREACHABLE = 3'd2,
        STAT_CANCELLED   = 3'd3,
        STAT_STALE       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_EXEC,
        ST_WALK,
        ST_WLAST,
        ST_OUT
    } ght_state_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [5:0]         handle_index;
        logic [15:0]        handle_generation;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [31:0]        topo_rev;
        logic [31:0]        cost_rev;
        logic               field_ready;
        logic [2:0]         new_status;
    } ght_cmd_t;

    typedef struct packed {
        logic               ok;
        logic [5:0]         out_index;
        logic [15:0]        out_generation;
        logic [2:0]         out_status;
        logic               out_has_field;
        logic signed [15:0] out_goal_x;
        logic signed [15:0] out_goal_y;
        logic [31:0]        out_topo_rev;
        logic [31:0]        out_cost_rev;
        logic [5:0]         active_count;
    } ght_rsp_t;

endpackage

[rtl/core/ght_stream_if.sv]
// Valid/ready channel that carries one payload per transfer.
interface ght_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ght_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/generational_handle_table_top.sv]
// Generational handle table: slot table with handles of index and generation.
// Store, set status, release and lookup read the slot memories, check and write
// back, then load the output register. Create first finds the lowest free slot;
// early rejects go straight to loading the output register.
// Mark stale walks one slot per cycle through the metadata memory.
// After reset a clearing pass sets every generation to 1 before any transfer.
module generational_handle_table_top
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF,
    parameter int REV_BITS   = REV_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ght_stream_if.sink   cmd,
    ght_stream_if.source rsp
);

    localparam int IW      = $clog2(SLOT_COUNT);
    localparam int OW      = OCC_WORD_BITS;
    localparam int BW      = $clog2(OW);
    localparam int NWORDS  = (SLOT_COUNT + OW - 1) / OW;
    localparam int WAW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int FULL_N  = 2 ** WAW;
    localparam int XW      = WAW + BW;
    localparam int META_W  = GEN_BITS + 4;
    localparam int DATA_W  = 2 * COORD_BITS + 2 * REV_BITS;
    localparam logic [FULL_N-1:0] FULL_RESET = {FULL_N{1'b1}} << NWORDS;
    localparam logic [IW-1:0]     LAST_SLOT  = IW'(SLOT_COUNT - 1);

    ght_state_t        state_reg, state_next;
    ght_cmd_t          cmd_reg, cmd_next;
    logic [XW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic [IW-1:0]     walk_rd_reg, walk_rd_next;
    logic [IW-1:0]     walk_wr_reg, walk_wr_next;
    logic              walk_pend_reg, walk_pend_next;
    logic [FULL_N-1:0] full_reg, full_next;
    logic [IW-1:0]     live_reg, live_next;
    ght_rsp_t          res_reg, res_next;
    logic              out_valid_reg;
    ght_rsp_t          out_data_reg;

    logic              meta_we, meta_re;
    logic [IW-1:0]     meta_waddr, meta_raddr;
    logic [META_W-1:0] meta_wdata, meta_rdata;
    logic              data_we, data_re;
    logic [IW-1:0]     data_waddr, data_raddr;
    logic [DATA_W-1:0] data_wdata, data_rdata;
    logic              occ_we, occ_re;
    logic [WAW-1:0]    occ_waddr, occ_raddr;
    logic [OW-1:0]     occ_wdata, occ_rdata;

    logic                         accept;
    logic                         load_out;
    logic                         in_idx_ok;
    logic [XW-1:0]                in_idx_x;
    logic [WAW-1:0]               idx_word;
    logic [BW-1:0]                idx_bit;
    logic [OW-1:0]                idx_onehot;
    logic [WAW-1:0]               free_word;
    logic                         any_free;
    logic [OW-1:0]                word_mask;
    logic [BW-1:0]                found_bit;
    logic [GEN_BITS-1:0]          rd_gen;
    logic [GEN_BITS-1:0]          gen_bump;
    logic [2:0]                   rd_status;
    logic                         rd_field;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic [REV_BITS-1:0]          rd_topo, rd_cost;
    logic signed [COORD_BITS-1:0] cmd_x, cmd_y;
    logic [REV_BITS-1:0]          cmd_topo, cmd_cost;
    logic                         slot_hit;
    logic [XW-1:0]                walk_rd_x, walk_wr_x;
    logic                         walk_occ;
    logic [OW-1:0]                create_word;
    logic [2:0]                   set_stat;
    logic                         set_field;
    logic [2:0]                   store_status;

    function automatic logic [OW-1:0] occ_mask(input logic [WAW-1:0] w);
        logic [OW-1:0] m;
        int            slot;
        for (int b = 0; b < OW; b++)
        begin
            slot = int'(w) * OW + b;
            m[b] = (slot == 0) || (slot >= SLOT_COUNT);
        end
        return m;
    endfunction

    function automatic logic [WAW-1:0] first_zero_word(input logic [FULL_N-1:0] v);
        logic [WAW-1:0] pos;
        pos = '0;
        for (int i = FULL_N - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                pos = WAW'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [BW-1:0] first_zero_bit(input logic [OW-1:0] v);
        logic [BW-1:0] pos;
        pos = '0;
        for (int i = OW - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                pos = BW'(i);
            end
        end
        return pos;
    endfunction

    function automatic ght_rsp_t fail_rsp(input logic [IW-1:0] live);
        ght_rsp_t r;
        r = '0;
        r.active_count = 6'(live);
        return r;
    endfunction

    function automatic ght_rsp_t report(
        input logic [XW-1:0]                idx,
        input logic [GEN_BITS-1:0]          gen,
        input logic [2:0]                   status,
        input logic                         field,
        input logic signed [COORD_BITS-1:0] gx,
        input logic signed [COORD_BITS-1:0] gy,
        input logic [REV_BITS-1:0]          topo,
        input logic [REV_BITS-1:0]          cost,
        input logic [IW-1:0]                live
    );
        ght_rsp_t r;
        r.ok             = 1'b1;
        r.out_index      = 6'(idx);
        r.out_generation = 16'(gen);
        r.out_status     = status;
        r.out_has_field  = field;
        r.out_goal_x     = 16'(gx);
        r.out_goal_y     = 16'(gy);
        r.out_topo_rev   = 32'(topo);
        r.out_cost_rev   = 32'(cost);
        r.active_count   = 6'(live);
        return r;
    endfunction

    ght_ram #(.WIDTH(META_W), .DEPTH(SLOT_COUNT)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    ght_ram #(.WIDTH(DATA_W), .DEPTH(SLOT_COUNT)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    ght_ram #(.WIDTH(OW), .DEPTH(FULL_N)) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .re    (occ_re),
        .raddr (occ_raddr),
        .rdata (occ_rdata)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || rsp.ready);

    assign in_idx_ok = (cmd.data.handle_index != 6'd0) &&
                       (32'(cmd.data.handle_index) < SLOT_COUNT);
    assign in_idx_x  = XW'(cmd.data.handle_index);

    assign idx_word   = idx_reg[XW-1:BW];
    assign idx_bit    = idx_reg[BW-1:0];
    assign idx_onehot = OW'(1) << idx_bit;
    assign free_word  = first_zero_word(full_reg);
    assign any_free   = ~&full_reg;
    assign word_mask  = occ_mask(idx_word);
    assign found_bit  = first_zero_bit(occ_rdata | word_mask);

    assign rd_gen    = meta_rdata[4 +: GEN_BITS];
    assign rd_status = meta_rdata[3:1];
    assign rd_field  = meta_rdata[0];
    assign rd_x      = $signed(data_rdata[2 * REV_BITS + COORD_BITS +: COORD_BITS]);
    assign rd_y      = $signed(data_rdata[2 * REV_BITS +: COORD_BITS]);
    assign rd_topo   = data_rdata[REV_BITS +: REV_BITS];
    assign rd_cost   = data_rdata[REV_BITS-1:0];

    assign cmd_x    = COORD_BITS'(cmd_reg.goal_x);
    assign cmd_y    = COORD_BITS'(cmd_reg.goal_y);
    assign cmd_topo = REV_BITS'(cmd_reg.topo_rev);
    assign cmd_cost = REV_BITS'(cmd_reg.cost_rev);

    assign gen_bump = ((rd_gen + 1'b1) == '0) ? GEN_BITS'(1) : rd_gen + 1'b1;
    assign slot_hit = occ_rdata[idx_bit] &&
                      (32'(rd_gen) == 32'(cmd_reg.handle_generation));

    assign walk_rd_x = XW'(walk_rd_reg);
    assign walk_wr_x = XW'(walk_wr_reg);
    assign walk_occ  = occ_rdata[walk_wr_x[BW-1:0]];

    assign create_word  = occ_rdata | idx_onehot;
    assign store_status = cmd_reg.field_ready ? STAT_READY : STAT_UNREACHABLE;
    assign set_stat     = cmd_reg.new_status;
    assign set_field    = (cmd_reg.new_status == STAT_READY) ? rd_field : 1'b0;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        walk_rd_next   = walk_rd_reg;
        walk_wr_next   = walk_wr_reg;
        walk_pend_next = walk_pend_reg;
        full_next      = full_reg;
        live_next      = live_reg;
        res_next       = res_reg;

        meta_we    = 1'b0;
        meta_waddr = idx_reg[IW-1:0];
        meta_wdata = '0;
        meta_re    = 1'b0;
        meta_raddr = idx_reg[IW-1:0];
        data_we    = 1'b0;
        data_waddr = idx_reg[IW-1:0];
        data_wdata = '0;
        data_re    = 1'b0;
        data_raddr = idx_reg[IW-1:0];
        occ_we     = 1'b0;
        occ_waddr  = idx_word;
        occ_wdata  = '0;
        occ_re     = 1'b0;
        occ_raddr  = idx_word;

        case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = {GEN_BITS'(1), STAT_PENDING, 1'b0};
                if (32'(clr_reg) < NWORDS)
                begin
                    occ_we    = 1'b1;
                    occ_waddr = WAW'(clr_reg);
                    occ_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd.data;
                    case (cmd.data.func)
                        FN_CREATE:
                        begin
                            if (any_free)
                            begin
                                occ_re     = 1'b1;
                                occ_raddr  = free_word;
                                idx_next   = {free_word, BW'(0)};
                                state_next = ST_FIND;
                            end
                            else
                            begin
                                res_next   = fail_rsp(live_reg);
                                state_next = ST_OUT;
                            end
                        end
                        FN_STORE, FN_SET, FN_RELEASE, FN_LOOKUP:
                        begin
                            if (in_idx_ok)
                            begin
                                idx_next   = in_idx_x;
                                meta_re    = 1'b1;
                                meta_raddr = in_idx_x[IW-1:0];
                                data_re    = 1'b1;
                                data_raddr = in_idx_x[IW-1:0];
                                occ_re     = 1'b1;
                                occ_raddr  = in_idx_x[XW-1:BW];
                                state_next = ST_EXEC;
                            end
                            else
                            begin
                                res_next   = fail_rsp(live_reg);
                                state_next = ST_OUT;
                            end
                        end
                        FN_STALE:
                        begin
                            walk_rd_next   = IW'(1);
                            walk_pend_next = 1'b0;
                            state_next     = ST_WALK;
                        end
                        default:
                        begin
                            res_next   = fail_rsp(live_reg);
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_FIND:
            begin
                idx_next   = {idx_word, found_bit};
                meta_re    = 1'b1;
                meta_raddr = IW'({idx_word, found_bit});
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                state_next = ST_OUT;
                res_next   = fail_rsp(live_reg);
                case (cmd_reg.func)
                    FN_CREATE:
                    begin
                        meta_we              = 1'b1;
                        meta_wdata           = {rd_gen, STAT_PENDING, 1'b0};
                        data_we              = 1'b1;
                        data_wdata           = {cmd_x, cmd_y, cmd_topo, cmd_cost};
                        occ_we               = 1'b1;
                        occ_wdata            = create_word;
                        full_next[idx_word]  = &(create_word | word_mask);
                        live_next            = live_reg + 1'b1;
                        res_next             = report(idx_reg, rd_gen, STAT_PENDING, 1'b0,
                                                      cmd_x, cmd_y, cmd_topo, cmd_cost,
                                                      live_reg + 1'b1);
                    end
                    FN_STORE:
                    begin
                        if (slot_hit)
                        begin
                            meta_we    = 1'b1;
                            meta_wdata = {rd_gen, store_status, 1'b1};
                            data_we    = 1'b1;
                            data_wdata = {rd_x, rd_y, cmd_topo, cmd_cost};
                            res_next   = report(idx_reg, rd_gen, store_status, 1'b1,
                                                rd_x, rd_y, cmd_topo, cmd_cost, live_reg);
                        end
                    end
                    FN_SET:
                    begin
                        if (slot_hit && (cmd_reg.new_status <= STAT_STALE))
                        begin
                            meta_we    = 1'b1;
                            meta_wdata = {rd_gen, set_stat, set_field};
                            res_next   = report(idx_reg, rd_gen, set_stat, set_field,
                                                rd_x, rd_y, rd_topo, rd_cost, live_reg);
                        end
                    end
                    FN_RELEASE:
                    begin
                        if (slot_hit)
                        begin
                            meta_we             = 1'b1;
                            meta_wdata          = {gen_bump, STAT_PENDING, 1'b0};
                            occ_we              = 1'b1;
                            occ_wdata           = occ_rdata & ~idx_onehot;
                            full_next[idx_word] = 1'b0;
                            live_next           = live_reg - 1'b1;
                            res_next            = fail_rsp(live_reg - 1'b1);
                            res_next.ok         = 1'b1;
                        end
                    end
                    FN_LOOKUP:
                    begin
                        if (slot_hit)
                        begin
                            res_next = report(idx_reg, rd_gen, rd_status, rd_field,
                                              rd_x, rd_y, rd_topo, rd_cost, live_reg);
                        end
                    end
                    default:
                    begin
                        res_next = fail_rsp(live_reg);
                    end
                endcase
            end

            ST_WALK, ST_WLAST:
            begin
                if (walk_pend_reg && walk_occ && (rd_status != STAT_CANCELLED))
                begin
                    meta_we    = 1'b1;
                    meta_waddr = walk_wr_reg;
                    meta_wdata = {rd_gen, STAT_STALE, 1'b0};
                end
                if (state_reg == ST_WALK)
                begin
                    meta_re        = 1'b1;
                    meta_raddr     = walk_rd_reg;
                    occ_re         = 1'b1;
                    occ_raddr      = walk_rd_x[XW-1:BW];
                    walk_wr_next   = walk_rd_reg;
                    walk_pend_next = 1'b1;
                    walk_rd_next   = walk_rd_reg + 1'b1;
                    if (walk_rd_reg == LAST_SLOT)
                    begin
                        state_next = ST_WLAST;
                    end
                end
                else
                begin
                    walk_pend_next = 1'b0;
                    res_next       = fail_rsp(live_reg);
                    res_next.ok    = 1'b1;
                    state_next     = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            walk_pend_reg <= 1'b0;
            full_reg      <= FULL_RESET;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            walk_pend_reg <= walk_pend_next;
            full_reg      <= full_next;
            live_reg      <= live_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        walk_rd_reg <= walk_rd_next;
        walk_wr_reg <= walk_wr_next;
        res_reg     <= res_next;
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

endmodule
